// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl of the nested tlv validator
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ntlv_pkg.sv =====
// types and constants of the nested tlv validator
// no dependencies; imported by nested_tlv_validator and its bench
package ntlv_pkg;

    localparam int unsigned OFS_W     = 16;
    localparam int unsigned BUDGET_W  = 32;
    localparam int unsigned CNT_OUT_W = 7;
    localparam int unsigned STATUS_W  = 3;

    // header costs and limits
    localparam logic [BUDGET_W-1:0] HDR_COST   = 32'd4;
    localparam logic [OFS_W-1:0]    HDR_BYTES  = 16'd3;
    localparam int unsigned         NEST_BIT   = 7;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_OVERRUN = 3'd2,
        ST_NESTING = 3'd3,
        ST_VALUE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

endpackage

// ===== rtl/core/nested_tlv_validator.sv =====
// nested tlv validator: request register, single-pass parser, result register
// depends on ntlv_pkg and assert_macros.svh
//
// Usage
//   Input channel (i_in_valid / o_in_stall): a request with i_mode = 0 opens a
//   message of i_message_length bytes with a work budget of i_budget_in; a
//   request with i_mode = 1 carries one message byte in i_data_byte.
//   Output channel (o_out_valid / i_out_stall): at most one result per message,
//   either the first error found or ok once the outermost level is complete.
//   Bytes after a verdict and before the next start are dropped with no result.
//   A request that ends a message gives its result in the result register,
//   after the request register. Throughput: one request per cycle while the
//   result drains, since the whole header and level-close work for a byte fits
//   in one pass between the two registers; the level ends are compared in parallel.
//   When the receiver stalls, the result register holds; any request then
//   waits in the request register and o_in_stall rises until the result drains.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to idle; the level end table is written before it is read and
//   needs no reset.
module nested_tlv_validator
    import ntlv_pkg::*;
#(
    parameter int unsigned MAX_NEST     = 4,
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [OFS_W-1:0]     i_message_length,
    input  logic [BUDGET_W-1:0]  i_budget_in,
    input  logic [7:0]           i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BUDGET_W-1:0]  o_remaining_budget,
    output logic [CNT_OUT_W-1:0] o_element_count
);
    `include "assert_macros.svh"

    localparam int unsigned LW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    // request register
    logic                r_in_valid;
    logic                r_in_mode;
    logic [OFS_W-1:0]    r_in_len;
    logic [BUDGET_W-1:0] r_in_budget;
    logic [7:0]          r_in_byte;

    // parser state
    logic [OFS_W-1:0]    r_offset,  n_offset;
    logic [LW-1:0]       r_level,   n_level;
    t_phase              r_phase,   n_phase;
    logic [7:0]          r_type,    n_type;
    logic [OFS_W-1:0]    r_len,     n_len;
    logic [CW-1:0]       r_count,   n_count;
    logic [BUDGET_W-1:0] r_budget,  n_budget;
    logic                r_active,  n_active;
    logic [OFS_W-1:0]    r_ends [MAX_NEST];

    // result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [BUDGET_W-1:0] r_out_budget;
    logic [CW-1:0]       r_out_count;

    logic                fire;
    logic                end_we;
    logic [LW-1:0]       end_idx;
    logic [OFS_W-1:0]    end_data;
    logic                do_settle;
    logic [OFS_W-1:0]    s_offset;
    logic [LW-1:0]       s_level;
    logic [BUDGET_W-1:0] s_budget;
    logic [OFS_W-1:0]    s_ends [MAX_NEST];
    logic [MAX_NEST-1:0] lvl_eq;
    logic [MAX_NEST-1:0] lvl_short;
    logic                sel_found;
    logic [LW-1:0]       sel_level;
    logic                sel_short;
    logic                v_valid;
    t_status             v_status;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    // a request is processed once the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_mode   <= i_mode;
            r_in_len    <= i_message_length;
            r_in_budget <= i_budget_in;
            r_in_byte   <= i_data_byte;
        end
    end

    // byte / start handling, followed by level close and header checks
    always_comb begin
        logic [OFS_W-1:0] off1;
        logic [OFS_W-1:0] full_len;
        logic [OFS_W-1:0] cur_end;
        logic [LW:0]      lv_p1;

        off1      = r_offset + OFS_W'(1);
        full_len  = {r_in_byte, r_len[7:0]};
        cur_end   = r_ends[r_level];
        lv_p1     = {1'b0, r_level} + (LW+1)'(1);

        n_offset  = r_offset;
        n_level   = r_level;
        n_phase   = r_phase;
        n_type    = r_type;
        n_len     = r_len;
        n_count   = r_count;
        n_active  = r_active;
        end_we    = 1'b0;
        end_idx   = r_level;
        end_data  = r_in_len;
        do_settle = 1'b0;
        s_budget  = r_budget;
        v_valid   = 1'b0;
        v_status  = ST_OK;

        if (fire) begin
            if (r_in_mode == MODE_START) begin
                n_offset  = '0;
                n_level   = '0;
                n_phase   = PH_TYPE;
                n_type    = '0;
                n_len     = '0;
                n_count   = '0;
                n_active  = 1'b1;
                s_budget  = r_in_budget;
                end_we    = 1'b1;
                end_idx   = '0;
                end_data  = r_in_len;
                do_settle = 1'b1;
            end else if (r_active) begin
                unique case (r_phase)
                    PH_TYPE: begin
                        n_type   = r_in_byte;
                        n_offset = off1;
                        n_phase  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len    = {8'd0, r_in_byte};
                        n_offset = off1;
                        n_phase  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_len    = full_len;
                        n_offset = off1;
                        if (off1 > cur_end || full_len > (cur_end - off1)) begin
                            v_valid  = 1'b1;
                            v_status = ST_OVERRUN;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_phase = PH_TYPE;
                            if (r_type[NEST_BIT]) begin
                                if (lv_p1 >= (LW+1)'(MAX_NEST) || full_len == '0) begin
                                    v_valid  = 1'b1;
                                    v_status = ST_NESTING;
                                end else begin
                                    n_level   = lv_p1[LW-1:0];
                                    end_we    = 1'b1;
                                    end_idx   = lv_p1[LW-1:0];
                                    end_data  = off1 + full_len;
                                    do_settle = 1'b1;
                                end
                            end else if (r_budget < BUDGET_W'(full_len)) begin
                                v_valid  = 1'b1;
                                v_status = ST_VALUE;
                            end else begin
                                s_budget = r_budget - BUDGET_W'(full_len);
                                if (full_len != '0) begin
                                    n_phase = PH_SKIP;
                                end else begin
                                    do_settle = 1'b1;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_offset = off1;
                        if (r_len != '0) begin
                            n_len = r_len - OFS_W'(1);
                        end
                        if (n_len == '0) begin
                            n_phase   = PH_TYPE;
                            do_settle = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_TYPE;
                    end
                endcase
            end
        end

        s_offset = n_offset;
        s_level  = n_level;
        n_budget = s_budget;

        // per-level compares against the updated end table
        for (int l = 0; l < MAX_NEST; l++) begin
            s_ends[l]    = (end_we && end_idx == LW'(l)) ? end_data : r_ends[l];
            lvl_eq[l]    = (s_offset == s_ends[l]);
            lvl_short[l] = (s_offset > s_ends[l]) || ((s_ends[l] - s_offset) < HDR_BYTES);
        end

        // closing walks down from the open level until an end is not reached
        sel_found = 1'b0;
        sel_level = '0;
        sel_short = 1'b0;
        for (int l = MAX_NEST - 1; l >= 0; l--) begin
            if (LW'(l) <= s_level && !sel_found && !lvl_eq[l]) begin
                sel_found = 1'b1;
                sel_level = LW'(l);
                sel_short = lvl_short[l];
            end
        end

        if (do_settle) begin
            if (!sel_found) begin
                v_valid  = 1'b1;
                v_status = ST_OK;
                n_level  = '0;
            end else if (s_budget < HDR_COST || sel_short ||
                         n_count >= CW'(MAX_ELEMENTS)) begin
                v_valid  = 1'b1;
                v_status = ST_SHORT;
                n_level  = sel_level;
            end else begin
                n_budget = s_budget - HDR_COST;
                n_level  = sel_level;
            end
        end

        if (v_valid) begin
            n_active = 1'b0;
            n_phase  = PH_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_level  <= '0;
            r_phase  <= PH_TYPE;
            r_type   <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_budget <= '0;
            r_active <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_level  <= n_level;
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_len    <= n_len;
            r_count  <= n_count;
            r_budget <= n_budget;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            r_ends[end_idx] <= end_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && v_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && v_valid) begin
            r_out_status <= v_status;
            r_out_budget <= s_budget;
            r_out_count  <= n_count;
        end
    end

    assign cnt_ext            = {{CNT_OUT_W{1'b0}}, r_out_count};
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_remaining_budget = r_out_budget;
    assign o_element_count    = cnt_ext[CNT_OUT_W-1:0];

    `CHK_IMPLY(a_idle_phase, i_clk, i_rst_n, !r_active, r_phase == PH_TYPE, "idle parser left mid-header")
    `CHK_IMPLY(a_skip_len, i_clk, i_rst_n, r_active && r_phase == PH_SKIP, r_len != '0, "value skip with zero bytes left")
    `CHK_IMPLY(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ELEMENTS), "element count above limit")
    `CHK_NEXT(a_verdict_out, i_clk, i_rst_n, fire && v_valid, r_out_valid && !r_active, "verdict not registered")
    `CHK_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "stall without a full pipeline")

endmodule

// ===== bench/nested_tlv_validator_test.sv =====
// self-checking bench for nested_tlv_validator: directed rows, then random tlv messages
// depends on ntlv_pkg and the validator; random verdicts come from an in-bench parser model
`timescale 1ns / 100ps

module nested_tlv_validator_test;
    import ntlv_pkg::*;

    localparam int unsigned NEST_LIMIT    = 4;
    localparam int unsigned ELEMENT_LIMIT = 64;
    localparam int unsigned RANDOM_ITEMS  = 1100;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned ROW_COUNT     = 23;

    typedef struct packed {
        logic                 mode;
        logic [OFS_W-1:0]     len;
        logic [BUDGET_W-1:0]  budget;
        logic [7:0]           data;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [BUDGET_W-1:0]  budget;
        logic [CNT_OUT_W-1:0] count;
    } t_verdict;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_verdict fixed;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode = MODE_START;
    logic [OFS_W-1:0]     i_message_length = '0;
    logic [BUDGET_W-1:0]  i_budget_in = '0;
    logic [7:0]           i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [BUDGET_W-1:0]  o_remaining_budget;
    logic [CNT_OUT_W-1:0] o_element_count;

    nested_tlv_validator #(
        .MAX_NEST     (NEST_LIMIT),
        .MAX_ELEMENTS (ELEMENT_LIMIT)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_message_length   (i_message_length),
        .i_budget_in        (i_budget_in),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_remaining_budget (o_remaining_budget),
        .o_element_count    (o_element_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // parser model state
    logic [OFS_W-1:0]              p_offset;
    logic [OFS_W-1:0]              p_ends [NEST_LIMIT];
    logic [$clog2(NEST_LIMIT)-1:0] p_level;
    t_phase                        p_phase;
    logic [7:0]                    p_type;
    logic [OFS_W-1:0]              p_len;
    logic [CNT_OUT_W-1:0]          p_count;
    logic [BUDGET_W-1:0]           p_budget;
    logic                          p_open;

    t_verdict    pending_verdicts [$];
    logic [7:0]  msg_bytes [$];
    t_row        directed [ROW_COUNT];
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned verdicts_seen = 0;
    int unsigned live_items = 0;
    int unsigned sent_items = 0;
    int unsigned messages = 0;
    int unsigned status_tally [5];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    function automatic void clear_parser();
        p_offset = '0;
        p_level  = '0;
        p_phase  = PH_TYPE;
        p_type   = '0;
        p_len    = '0;
        p_count  = '0;
        p_budget = '0;
        p_open   = 1'b0;
        for (int i = 0; i < NEST_LIMIT; i++) p_ends[i] = '0;
    endfunction

    // pop finished levels, then check room for the next header; 1 means a verdict
    function automatic bit close_levels(output t_status st);
        st = ST_OK;
        while (p_offset == p_ends[p_level] && p_level != 0) p_level = p_level - 1'b1;
        if (p_offset == p_ends[p_level]) return 1'b1;
        if (p_budget < HDR_COST || p_offset > p_ends[p_level] ||
            p_ends[p_level] - p_offset < HDR_BYTES || p_count >= ELEMENT_LIMIT) begin
            st = ST_SHORT;
            return 1'b1;
        end
        p_budget = p_budget - HDR_COST;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output t_status st);
        st = ST_OK;
        case (p_phase)
            PH_TYPE: begin
                p_type   = b;
                p_offset = p_offset + 1'b1;
                p_phase  = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO: begin
                p_len    = {8'h00, b};
                p_offset = p_offset + 1'b1;
                p_phase  = PH_LEN_HI;
                return 1'b0;
            end
            PH_LEN_HI: begin
                p_len[15:8] = b;
                p_offset    = p_offset + 1'b1;
                if (p_offset > p_ends[p_level] || p_len > p_ends[p_level] - p_offset) begin
                    st = ST_OVERRUN;
                    return 1'b1;
                end
                p_count = p_count + 1'b1;
                p_phase = PH_TYPE;
                if (p_type[NEST_BIT]) begin
                    if (p_level == NEST_LIMIT - 1 || p_len == 0) begin
                        st = ST_NESTING;
                        return 1'b1;
                    end
                    p_level         = p_level + 1'b1;
                    p_ends[p_level] = p_offset + p_len;
                    return close_levels(st);
                end
                if (p_budget < {16'h0000, p_len}) begin
                    st = ST_VALUE;
                    return 1'b1;
                end
                p_budget = p_budget - {16'h0000, p_len};
                if (p_len != 0) begin
                    p_phase = PH_SKIP;
                    return 1'b0;
                end
                return close_levels(st);
            end
            default: begin
                p_offset = p_offset + 1'b1;
                if (p_len > 0) p_len = p_len - 1'b1;
                if (p_len == 0) begin
                    p_phase = PH_TYPE;
                    return close_levels(st);
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic bit predict_verdict(input t_request req, output t_verdict v);
        bit      hit;
        t_status st;
        v = '0;
        if (req.mode == MODE_START) begin
            clear_parser();
            p_budget  = req.budget;
            p_ends[0] = req.len;
            p_open    = 1'b1;
            hit = close_levels(st);
        end else if (!p_open) begin
            return 1'b0;
        end else begin
            hit = parse_byte(req.data, st);
        end
        if (!hit) return 1'b0;
        p_open   = 1'b0;
        v.status = st;
        v.budget = p_budget;
        v.count  = p_count;
        return 1'b1;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch at cycle %0d: %s, got %0h want %0h", cycles, what, got, want);
    endtask

    // drive one request, hold it until accepted, then log its verdict
    task automatic send_request(input t_request req, input bit typed, input t_verdict fixed);
        t_verdict v;
        bit       hit;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= req.mode;
        i_message_length <= req.len;
        i_budget_in      <= req.budget;
        i_data_byte      <= req.data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items++;
        if (req.mode == MODE_START || p_open) live_items++;
        if (req.mode == MODE_START) messages++;
        hit = predict_verdict(req, v);
        if (typed) begin
            pending_verdicts.push_back(fixed);
        end else if (hit) begin
            pending_verdicts.push_back(v);
        end
    endtask

    // random nested message into msg_bytes, with a start request that may not fit it
    task automatic compose_message(output t_request head);
        int unsigned open_at [NEST_LIMIT];
        int          depth;
        int          steps;
        int          pick;
        int          n;
        int unsigned work;
        int unsigned span;
        logic [15:0] leaf_len;
        msg_bytes.delete();
        depth = 0;
        work  = 0;
        if ($urandom_range(0, 19) == 0) begin
            // flat run of empty leaves around the element limit
            n = $urandom_range(ELEMENT_LIMIT - 4, ELEMENT_LIMIT + 4);
            for (int i = 0; i < n; i++) begin
                msg_bytes.push_back(8'($urandom_range(0, 127)));
                msg_bytes.push_back(8'h00);
                msg_bytes.push_back(8'h00);
                work += 4;
            end
        end else begin
            steps = $urandom_range(1, 8);
            for (int i = 0; i < steps || depth > 0; i++) begin
                pick = (i < steps) ? $urandom_range(0, 9) : 4;
                if (pick < 3 && (depth < NEST_LIMIT - 1 ||
                    (depth == NEST_LIMIT - 1 && $urandom_range(0, 5) == 0))) begin
                    msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                    open_at[depth] = msg_bytes.size();
                    msg_bytes.push_back(8'h00);
                    msg_bytes.push_back(8'h00);
                    depth++;
                    work += 4;
                end else if (pick < 5 && depth > 0 &&
                    (msg_bytes.size() > open_at[depth-1] + 2 || i >= steps)) begin
                    // patch the container length now that its content is known
                    span = msg_bytes.size() - open_at[depth-1] - 2;
                    msg_bytes[open_at[depth-1]]     = span[7:0];
                    msg_bytes[open_at[depth-1] + 1] = span[15:8];
                    depth--;
                end else begin
                    leaf_len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                    msg_bytes.push_back(8'($urandom_range(0, 127)));
                    msg_bytes.push_back(leaf_len[7:0]);
                    msg_bytes.push_back(leaf_len[15:8]);
                    for (int k = 0; k < leaf_len; k++) msg_bytes.push_back(8'($urandom));
                    work += 4 + leaf_len;
                end
            end
        end

        head.mode = MODE_START;
        head.data = 8'($urandom);
        head.len  = 16'(msg_bytes.size());
        pick = $urandom_range(0, 9);
        case (pick)
            0:       head.budget = (work > 0) ? $urandom_range(0, work - 1) : 32'd0;
            1:       head.budget = work;
            2:       head.budget = 32'hFFFF_FFFF;
            3:       head.budget = $urandom;
            default: head.budget = work + $urandom_range(0, 64);
        endcase
        pick = $urandom_range(0, 15);
        case (pick)
            0: head.len = head.len + 16'($urandom_range(1, 6));
            1: head.len = 16'($urandom_range(0, msg_bytes.size() - 1));
            2: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            3: begin
                n = $urandom_range(1, msg_bytes.size());
                repeat (n) void'(msg_bytes.pop_back());
            end
            4: head.len = 16'($urandom);
            default: ;
        endcase
        // trailing bytes that land after the verdict must be dropped
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
                     pending_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            verdicts_seen++;
            if (o_status <= ST_VALUE) status_tally[o_status]++;
            if (pending_verdicts.size() == 0) begin
                flag_error("verdict with no request pending", 32'(o_status), 32'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_status !== want.status)
                    flag_error("status", 32'(o_status), 32'(want.status));
                if (o_remaining_budget !== want.budget)
                    flag_error("remaining budget", o_remaining_budget, want.budget);
                if (o_element_count !== want.count)
                    flag_error("element count", 32'(o_element_count), 32'(want.count));
            end
        end
    end

    initial begin : stimulus
        t_request    req;
        int unsigned rand_start;
        int unsigned phase;
        for (int i = 0; i < 5; i++) status_tally[i] = 0;
        clear_parser();
        directed = '{
            // data while idle is dropped
            '{'{MODE_DATA,  16'd0,     32'd0,          8'hFF}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            // empty message, then budget and length too small for a header
            '{'{MODE_START, 16'd0,     32'hFFFF_FFFF,  8'h00}, 1'b1,
              '{ST_OK, 32'hFFFF_FFFF, 7'd0}},
            '{'{MODE_START, 16'hFFFF,  32'd3,          8'h00}, 1'b1, '{ST_SHORT, 32'd3, 7'd0}},
            '{'{MODE_START, 16'd2,     32'd100,        8'h00}, 1'b1, '{ST_SHORT, 32'd100, 7'd0}},
            // open message dropped by a fresh start, then one empty leaf spends it all
            '{'{MODE_START, 16'd9,     32'd7,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h7F}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_START, 16'd3,     32'd4,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h7F}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b1, '{ST_OK, 32'd0, 7'd1}},
            // value longer than the message
            '{'{MODE_START, 16'd5,     32'd100,        8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h01}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h05}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'hFF}, 1'b1,
              '{ST_OVERRUN, 32'd96, 7'd0}},
            // empty container, then a byte after the verdict
            '{'{MODE_START, 16'd3,     32'd100,        8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h80}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b1,
              '{ST_NESTING, 32'd96, 7'd1}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h12}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            // leaf value over the budget
            '{'{MODE_START, 16'd8,     32'd5,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h05}, 1'b0, '{ST_OK, 32'd0, 7'd0}},
            '{'{MODE_DATA,  16'd0,     32'd0,          8'h00}, 1'b1, '{ST_VALUE, 32'd1, 7'd1}}
        };

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].fixed);

        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            phase = (sent_items - rand_start) * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            compose_message(req);
            send_request(req, 1'b0, '0);
            foreach (msg_bytes[i]) begin
                req.mode   = MODE_DATA;
                req.len    = 16'($urandom);
                req.budget = $urandom;
                req.data   = msg_bytes[i];
                send_request(req, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            flag_error("verdicts never delivered", 32'(pending_verdicts.size()), 32'd0);

        $display("%0d requests sent, %0d parsed across %0d messages, %0d verdicts compared",
                 sent_items, live_items, messages, verdicts_seen);
        $display("verdict mix: ok %0d, short %0d, overrun %0d, nesting %0d, value %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
